>>> src/cor_pkg.sv
// Package for the midpoint circle rasterizer.
// Holds item and job struct types, opcode enum and fixed sizes; no dependencies.
package cor_pkg;

    localparam int DEC_BITS    = 14;
    localparam int PT_BITS     = 12;
    localparam int STEP_POINTS = 8;
    localparam int IDX_BITS    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam logic [IDX_BITS-1:0]  LAST_IDX    = IDX_BITS'(STEP_POINTS - 1);
    localparam logic [QCNT_BITS-1:0] QUEUE_FULL  = QCNT_BITS'(QUEUE_DEPTH);
    localparam logic [DEC_BITS-1:0]  DEC_INIT    = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0]  DEC_INC_POS = DEC_BITS'(10);
    localparam logic [DEC_BITS-1:0]  DEC_INC_NEG = DEC_BITS'(6);

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef struct packed {
        t_op        operation;
        logic [8:0] radius;
        logic [9:0] center_x;
        logic [9:0] center_y;
    } t_in_item;

    typedef struct packed {
        logic signed [PT_BITS-1:0] point_x;
        logic signed [PT_BITS-1:0] point_y;
        logic                      last_of_step;
        logic                      circle_done;
    } t_out_item;

    typedef struct packed {
        logic [PT_BITS-1:0] cx;
        logic [PT_BITS-1:0] cy;
        logic [PT_BITS-1:0] ox;
        logic [PT_BITS-1:0] oy;
        logic               done;
    } t_step_job;

endpackage

>>> src/circle_octant_rasterizer_top.sv
// Top level of the midpoint circle rasterizer.
// Instantiates cor_front, cor_queue and cor_back; depends on cor_pkg.
//
// A start item (operation 0) loads center and radius and produces nothing; a
// step item (operation 1) produces the eight mirrored points of the current
// octant position, one point per cycle while i_out_stall is low, the eighth
// flagged last_of_step and, for the final step of the circle, circle_done.
// Steps before a start or after the circle ends produce nothing. Items are
// taken one per cycle while the two-entry job queue has room; a point-producing
// step then keeps the single-port output sequencer busy until its eight points
// are out, so the sequencer sets the sustained rate of step items.
module circle_octant_rasterizer_top import cor_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_valid;
    t_step_job front_job;
    t_step_job head_job;

    cor_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    cor_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_head  (head_job)
    );

    cor_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> src/cor_front.sv
// Front end of the circle rasterizer: accepts items, keeps the octant walk state
// and pushes one job per emitting step. Depends on cor_pkg.
module cor_front import cor_pkg::*; #(
    parameter int COORD_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_queue_full,
    output logic      o_push,
    output t_step_job o_job
);

    localparam int XW = COORD_BITS + 2;

    logic [COORD_BITS-1:0] r_offset_x, n_offset_x;
    logic [COORD_BITS-1:0] r_offset_y, n_offset_y;
    logic [COORD_BITS-1:0] r_center_x, n_center_x;
    logic [COORD_BITS-1:0] r_center_y, n_center_y;
    logic [DEC_BITS-1:0]   r_decision, n_decision;
    logic                  r_active, n_active;

    logic                  accept;
    logic                  step;
    logic                  in_range;
    logic                  d_pos;
    logic                  done;
    logic [DEC_BITS-1:0]   x_d;
    logic [DEC_BITS-1:0]   y_d;
    logic [DEC_BITS-1:0]   dec_pos;
    logic [DEC_BITS-1:0]   dec_neg;
    logic [XW-1:0]         x_wide;
    logic [XW-1:0]         y_wide;

    assign o_in_stall = i_queue_full;

    always_comb begin
        accept   = i_in_valid && !i_queue_full;
        step     = accept && (i_in_item.operation == OP_STEP) && r_active;
        in_range = r_offset_x <= r_offset_y;
        d_pos    = !r_decision[DEC_BITS-1] && (r_decision != '0);
        x_d      = DEC_BITS'(r_offset_x);
        y_d      = DEC_BITS'(r_offset_y);
        dec_pos  = r_decision + ((x_d - y_d) << 2) + DEC_INC_POS;
        dec_neg  = r_decision + (x_d << 2) + DEC_INC_NEG;
        x_wide   = XW'(r_offset_x);
        y_wide   = XW'(r_offset_y);
        done     = d_pos ? ((x_wide + XW'(2)) > y_wide) : (r_offset_x == r_offset_y);
        o_push   = step && in_range;
    end

    always_comb begin
        n_offset_x = r_offset_x;
        n_offset_y = r_offset_y;
        n_center_x = r_center_x;
        n_center_y = r_center_y;
        n_decision = r_decision;
        n_active   = r_active;
        if (accept && (i_in_item.operation == OP_START)) begin
            n_center_x = COORD_BITS'(i_in_item.center_x);
            n_center_y = COORD_BITS'(i_in_item.center_y);
            n_offset_x = '0;
            n_offset_y = COORD_BITS'(i_in_item.radius);
            n_decision = DEC_INIT - (DEC_BITS'(i_in_item.radius) << 1);
            n_active   = 1'b1;
        end else if (step) begin
            if (!in_range || done) begin
                n_active = 1'b0;
            end else begin
                n_offset_x = r_offset_x + COORD_BITS'(1);
                n_offset_y = d_pos ? (r_offset_y - COORD_BITS'(1)) : r_offset_y;
                n_decision = d_pos ? dec_pos : dec_neg;
            end
        end
    end

    always_comb begin
        o_job.cx   = PT_BITS'(r_center_x);
        o_job.cy   = PT_BITS'(r_center_y);
        o_job.ox   = PT_BITS'(r_offset_x);
        o_job.oy   = PT_BITS'(r_offset_y);
        o_job.done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
        r_offset_x <= n_offset_x;
        r_offset_y <= n_offset_y;
        r_center_x <= n_center_x;
        r_center_y <= n_center_y;
        r_decision <= n_decision;
    end

`ifndef ASSERT_OFF
    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_item.operation == OP_START))
        |=> (r_active && (r_offset_x == '0)))
        else $error("start item did not load a fresh octant walk");
`endif

endmodule

>>> src/cor_queue.sv
// Short job queue between the front and back parts of the circle rasterizer.
// Depends on cor_pkg for the job type and depth.
module cor_queue import cor_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_step_job i_job,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_step_job o_head
);

    t_step_job             r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr;
    logic [QPTR_BITS-1:0]  r_rd_ptr;
    logic [QCNT_BITS-1:0]  r_count;

    assign o_full  = r_count == QUEUE_FULL;
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_BITS'(1);
                2'b01:   r_count <= r_count - QCNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from an empty queue");
`endif

endmodule

>>> src/cor_back.sv
// Back end of the circle rasterizer: walks the eight mirrored points of each job
// into a registered output stage. Depends on cor_pkg.
module cor_back import cor_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_step_job i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic [IDX_BITS-1:0] r_index;
    logic                r_out_valid;
    t_out_item           r_out_item;
    t_out_item           n_out_item;

    logic                advance;
    logic                last;
    logic [PT_BITS-1:0]  a;
    logic [PT_BITS-1:0]  b;

    always_comb begin
        advance = i_job_valid && (!r_out_valid || !i_out_stall);
        last    = r_index == LAST_IDX;
        a       = r_index[2] ? i_job.oy : i_job.ox;
        b       = r_index[2] ? i_job.ox : i_job.oy;
        n_out_item.point_x      = $signed((r_index[0] ^ r_index[1]) ? (i_job.cx - a)
                                                                    : (i_job.cx + a));
        n_out_item.point_y      = $signed(r_index[0] ? (i_job.cy - b) : (i_job.cy + b));
        n_out_item.last_of_step = last;
        n_out_item.circle_done  = last && i_job.done;
        o_pop   = advance && last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_index     <= r_index + IDX_BITS'(1);
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

`ifndef ASSERT_OFF
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.circle_done) |-> o_out_item.last_of_step)
        else $error("circle end flagged on a point that does not close a step");
    a_index_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_index))
        else $error("point index moved without a point being produced");
`endif

endmodule
